FILE: design/stn_pkg.sv
// Shared types, character codes and byte classifiers for the search text normalizer.
package stn_pkg;

    // Default longest digit run of a numeric entity
    localparam int MAX_DIGITS_DEF = 8;

    // Configuration port geometry
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register word index of keep_ands
    localparam logic [APB_AW-3:0] REG_KEEP_ANDS = '0;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_SWALLOW = 8'hC2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_REPLAY,
        ST_FRESH,
        ST_END_CHK,
        ST_REPLAY_END,
        ST_EOS,
        ST_FLUSH
    } t_state;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ABSORB,
        OP_PUSH,
        OP_ENT_DONE,
        OP_MATCH_CLEAR,
        OP_REPLAY,
        OP_FRESH,
        OP_EOS,
        OP_FLUSH
    } t_op;

    // What the current byte does to an open look-ahead
    typedef enum logic [2:0] {
        FK_ABSORB,
        FK_PUSH,
        FK_ENT_DONE,
        FK_AND_DROP,
        FK_REPLAY,
        FK_FRESH
    } t_feed;

    // Status from datapath to controller
    typedef struct packed {
        t_feed feed_kind;
        logic  rep_done;
        logic  last_item;
        logic  and_complete;
        logic  match_open;
        logic  step_ok;
        logic  step_done;
    } t_status;

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Separator class, swallowing byte included
    function automatic logic f_is_sep(input logic [7:0] c);
        return (c == CH_NUL) || f_is_punct(c) || f_is_space(c) || (c == CH_SWALLOW);
    endfunction

endpackage

FILE: design/stn_ctrl.sv
// Controller FSM that steps the normalizer datapath one step per cycle unless output stalls.
module stn_ctrl
    import stn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_op     o_op,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and operation
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                unique case (i_status.feed_kind)
                    FK_ABSORB: begin
                        o_op    = OP_ABSORB;
                        n_state = ST_END_CHK;
                    end
                    FK_PUSH: begin
                        o_op    = OP_PUSH;
                        n_state = ST_END_CHK;
                    end
                    FK_ENT_DONE: begin
                        o_op = OP_ENT_DONE;
                        if (i_status.step_ok) begin
                            n_state = ST_END_CHK;
                        end
                    end
                    FK_AND_DROP: begin
                        o_op    = OP_MATCH_CLEAR;
                        n_state = ST_FRESH;
                    end
                    FK_REPLAY: begin
                        n_state = ST_REPLAY;
                    end
                    FK_FRESH: begin
                        n_state = ST_FRESH;
                    end
                    default: begin
                        n_state = ST_FRESH;
                    end
                endcase
            end
            // Replay held bytes, then treat the breaking byte afresh
            ST_REPLAY: begin
                if (i_status.rep_done) begin
                    o_op    = OP_MATCH_CLEAR;
                    n_state = ST_FRESH;
                end else begin
                    o_op = OP_REPLAY;
                end
            end
            ST_FRESH: begin
                o_op = OP_FRESH;
                if (i_status.step_ok && i_status.step_done) begin
                    n_state = ST_END_CHK;
                end
            end
            // Resolve an open match at the end of the string; other bytes go straight to flush
            ST_END_CHK: begin
                priority if (!i_status.last_item) begin
                    n_state = ST_FLUSH;
                end else if (i_status.and_complete) begin
                    o_op    = OP_MATCH_CLEAR;
                    n_state = ST_EOS;
                end else if (i_status.match_open) begin
                    n_state = ST_REPLAY_END;
                end else begin
                    n_state = ST_EOS;
                end
            end
            ST_REPLAY_END: begin
                if (i_status.rep_done) begin
                    o_op    = OP_MATCH_CLEAR;
                    n_state = ST_EOS;
                end else begin
                    o_op = OP_REPLAY;
                end
            end
            ST_EOS: begin
                o_op = OP_EOS;
                if (i_status.step_ok) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_op = OP_FLUSH;
                if (i_status.step_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/stn_datapath.sv
// Datapath: string state, look-ahead store, byte classifier, result hold and output stage.
module stn_datapath
    import stn_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    output t_status    o_status,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_keep_ands,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_has,
    output logic       o_out_eor,
    output logic       o_out_eos,
    output logic       o_out_alt
);

    localparam int PEND_DEPTH = MAX_DIGITS + 2;
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
    localparam int IDX_W      = $clog2(PEND_DEPTH);

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(PEND_DEPTH);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ENT,
        MODE_AND
    } t_mode;

    // String state
    logic [7:0]       r_cur;
    logic             r_last,       n_last;
    logic [7:0]       r_prev,       n_prev;
    logic             r_last_space, n_last_space;
    logic             r_out_empty,  n_out_empty;
    logic             r_last_dig,   n_last_dig;
    logic             r_absorb,     n_absorb;
    logic             r_altered,    n_altered;
    t_mode            r_mode,       n_mode;
    logic [CNT_W-1:0] r_pend_cnt,   n_pend_cnt;
    logic [CNT_W-1:0] r_rep_idx,    n_rep_idx;
    logic [7:0]       r_pend [PEND_DEPTH];

    // Result hold (last result of an item is known only when the item ends)
    logic       r_hold_v, n_hold_v;
    logic [7:0] r_hold_byte;
    logic       r_hold_has;
    logic       r_hold_eos;
    logic       r_hold_alt;

    // Output stage
    logic       r_out_v, n_out_v;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_eor;
    logic       r_out_eos;
    logic       r_out_alt;

    logic             out_load;
    logic             out_from_flush;
    logic             hold_load;
    logic             pend_we;
    logic [IDX_W-1:0] pend_wa;

    // Byte classifier and emission signals
    logic       use_pend;
    logic [7:0] pend_rd;
    logic [7:0] pb;
    logic       pl;
    logic       p_sep;
    logic       p_dig;
    logic       p_gap;
    logic       p_emit;
    logic [7:0] p_byte;
    logic       start_ent;
    logic       start_and;
    logic       plain_act;
    logic       emit_req;
    logic [7:0] emit_byte;
    logic       emit_has;
    logic       emit_eos;
    logic       emit_alt;
    logic       step_done;
    logic       out_free;
    logic       can_emit;
    logic       step_ok;
    t_feed      feed_kind;

    // Plain handling of one byte: held byte during replay, else the current one
    always_comb begin
        use_pend  = (i_op == OP_REPLAY);
        pend_rd   = r_pend[r_rep_idx[IDX_W-1:0]];
        pb        = use_pend ? pend_rd : r_cur;
        pl        = use_pend ? 1'b0 : r_last;
        p_sep     = f_is_sep(pb);
        p_dig     = f_is_digit(pb);
        p_gap     = !p_sep && (r_last_dig != p_dig) && !r_out_empty && !r_last_space;
        p_emit    = p_sep ? (!r_out_empty && !r_last_space) : 1'b1;
        p_byte    = (p_sep || p_gap) ? CH_SPACE : pb;
        start_ent = (r_cur == CH_AMP);
        start_and = (r_cur == CH_A) && !i_keep_ands &&
                    ((r_prev == CH_NUL) || f_is_space(r_prev));
    end

    // Classify the current byte against the open look-ahead
    always_comb begin
        feed_kind = FK_FRESH;
        if (r_absorb) begin
            feed_kind = FK_ABSORB;
        end else begin
            unique case (r_mode)
                MODE_ENT: begin
                    priority if (r_pend_cnt == CNT_ONE) begin
                        feed_kind = (r_cur == CH_HASH) ? FK_PUSH : FK_REPLAY;
                    end else if (f_is_digit(r_cur)) begin
                        feed_kind = (r_pend_cnt < CNT_DEPTH) ? FK_PUSH : FK_REPLAY;
                    end else if (r_cur == CH_SEMI) begin
                        feed_kind = FK_ENT_DONE;
                    end else begin
                        feed_kind = FK_REPLAY;
                    end
                end
                MODE_AND: begin
                    priority if ((r_pend_cnt == CNT_ONE && r_cur == CH_N) ||
                                 (r_pend_cnt == CNT_TWO && r_cur == CH_D)) begin
                        feed_kind = FK_PUSH;
                    end else if (r_pend_cnt == CNT_THREE &&
                                 (r_cur == CH_NUL || f_is_space(r_cur))) begin
                        feed_kind = FK_AND_DROP;
                    end else begin
                        feed_kind = FK_REPLAY;
                    end
                end
                default: begin
                    feed_kind = FK_FRESH;
                end
            endcase
        end
    end

    // Select the result this operation produces
    always_comb begin
        plain_act = 1'b0;
        emit_req  = 1'b0;
        emit_byte = CH_SPACE;
        emit_has  = 1'b1;
        emit_eos  = 1'b0;
        emit_alt  = 1'b0;
        step_done = 1'b1;
        unique case (i_op)
            OP_ENT_DONE: begin
                emit_req = r_out_empty || !r_last_space;
            end
            OP_REPLAY: begin
                plain_act = 1'b1;
                emit_req  = p_emit;
                emit_byte = p_byte;
                step_done = !p_gap;
            end
            OP_FRESH: begin
                if (!start_ent && !start_and) begin
                    plain_act = 1'b1;
                    emit_req  = p_emit;
                    emit_byte = p_byte;
                    step_done = !p_gap;
                end
            end
            OP_EOS: begin
                emit_req  = 1'b1;
                emit_byte = CH_NUL;
                emit_has  = 1'b0;
                emit_eos  = 1'b1;
                emit_alt  = r_altered;
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
        out_free = !r_out_v || i_out_ready;
        can_emit = !r_hold_v || out_free;
        step_ok  = (i_op == OP_FLUSH) ? (!r_hold_v || out_free) : (!emit_req || can_emit);
    end

    // Next state of the string, the hold and the output stage
    always_comb begin
        n_last         = r_last;
        n_prev         = r_prev;
        n_last_space   = r_last_space;
        n_out_empty    = r_out_empty;
        n_last_dig     = r_last_dig;
        n_absorb       = r_absorb;
        n_altered      = r_altered;
        n_mode         = r_mode;
        n_pend_cnt     = r_pend_cnt;
        n_rep_idx      = r_rep_idx;
        n_hold_v       = r_hold_v;
        n_out_v        = r_out_v && !i_out_ready;
        out_load       = 1'b0;
        out_from_flush = 1'b0;
        hold_load      = 1'b0;
        pend_we        = 1'b0;
        pend_wa        = r_pend_cnt[IDX_W-1:0];

        // Move the held result out and take the new one
        if (step_ok && emit_req) begin
            hold_load    = 1'b1;
            n_hold_v     = 1'b1;
            n_out_empty  = 1'b0;
            n_last_space = (emit_byte == CH_SPACE);
            if (r_hold_v) begin
                out_load = 1'b1;
                n_out_v  = 1'b1;
            end
        end

        // Side effects of plain handling
        if (step_ok && plain_act) begin
            if (p_sep) begin
                if (!p_emit) begin
                    n_altered = 1'b1;
                end
                if (pb == CH_SWALLOW && !pl) begin
                    n_absorb = 1'b1;
                end
            end else if (!p_gap) begin
                n_last_dig = p_dig;
            end
        end

        if (step_ok) begin
            unique case (i_op)
                OP_LOAD: begin
                    n_last    = i_in_last;
                    n_rep_idx = '0;
                end
                OP_ABSORB: begin
                    n_absorb = 1'b0;
                    n_prev   = r_cur;
                end
                OP_PUSH: begin
                    pend_we    = 1'b1;
                    n_pend_cnt = r_pend_cnt + CNT_ONE;
                    n_prev     = r_cur;
                end
                OP_ENT_DONE: begin
                    n_altered  = 1'b1;
                    n_mode     = MODE_NONE;
                    n_pend_cnt = '0;
                    n_prev     = r_cur;
                end
                OP_MATCH_CLEAR: begin
                    n_mode     = MODE_NONE;
                    n_pend_cnt = '0;
                    n_rep_idx  = '0;
                end
                OP_REPLAY: begin
                    if (!p_gap) begin
                        n_rep_idx = r_rep_idx + CNT_ONE;
                    end
                end
                OP_FRESH: begin
                    priority if (start_ent || start_and) begin
                        n_mode     = start_ent ? MODE_ENT : MODE_AND;
                        pend_we    = 1'b1;
                        pend_wa    = '0;
                        n_pend_cnt = CNT_ONE;
                        n_prev     = r_cur;
                    end else if (!p_gap) begin
                        n_prev = r_cur;
                    end else begin
                        n_prev = r_prev;
                    end
                end
                OP_EOS: begin
                    // Return the string state to its start
                    n_prev       = CH_NUL;
                    n_last_space = 1'b0;
                    n_out_empty  = 1'b1;
                    n_last_dig   = 1'b0;
                    n_absorb     = 1'b0;
                    n_altered    = 1'b0;
                    n_mode       = MODE_NONE;
                    n_pend_cnt   = '0;
                end
                OP_FLUSH: begin
                    if (r_hold_v) begin
                        out_load       = 1'b1;
                        out_from_flush = 1'b1;
                        n_out_v        = 1'b1;
                        n_hold_v       = 1'b0;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= 1'b0;
            r_prev       <= CH_NUL;
            r_last_space <= 1'b0;
            r_out_empty  <= 1'b1;
            r_last_dig   <= 1'b0;
            r_absorb     <= 1'b0;
            r_altered    <= 1'b0;
            r_mode       <= MODE_NONE;
            r_pend_cnt   <= '0;
            r_rep_idx    <= '0;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_last       <= n_last;
            r_prev       <= n_prev;
            r_last_space <= n_last_space;
            r_out_empty  <= n_out_empty;
            r_last_dig   <= n_last_dig;
            r_absorb     <= n_absorb;
            r_altered    <= n_altered;
            r_mode       <= n_mode;
            r_pend_cnt   <= n_pend_cnt;
            r_rep_idx    <= n_rep_idx;
            r_hold_v     <= n_hold_v;
            r_out_v      <= n_out_v;
        end
    end

    // Payload registers and look-ahead store
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_cur <= i_in_byte;
        end
        if (pend_we) begin
            r_pend[pend_wa] <= r_cur;
        end
        if (out_load) begin
            r_out_byte <= r_hold_byte;
            r_out_has  <= r_hold_has;
            r_out_eos  <= r_hold_eos;
            r_out_alt  <= r_hold_alt;
            r_out_eor  <= out_from_flush;
        end
        if (hold_load) begin
            r_hold_byte <= emit_byte;
            r_hold_has  <= emit_has;
            r_hold_eos  <= emit_eos;
            r_hold_alt  <= emit_alt;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.feed_kind    = feed_kind;
        o_status.rep_done     = (r_rep_idx == r_pend_cnt);
        o_status.last_item    = r_last;
        o_status.and_complete = (r_mode == MODE_AND) && (r_pend_cnt == CNT_THREE);
        o_status.match_open   = (r_mode != MODE_NONE);
        o_status.step_ok      = step_ok;
        o_status.step_done    = step_done;
    end

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out_byte;
    assign o_out_has   = r_out_has;
    assign o_out_eor   = r_out_eor;
    assign o_out_eos   = r_out_eos;
    assign o_out_alt   = r_out_alt;

endmodule

FILE: design/search_text_normalizer_top.sv
// Top level of the search text normalizer: stream ports, register port, controller and datapath.
// The block takes one byte of a lower-cased string per input item and returns its
// normalized bytes one result item at a time, with a bare end record after the last
// byte. It works on one item at a time. An ordinary byte is accepted, classified,
// processed and end-checked, and then its last result is released. A swallowed byte,
// or one that a look-ahead holds or that completes an entity, skips the separate process
// step. A byte that produces a further result is processed again for it. A failed
// entity or "and" match replays each held byte and then closes the replay; a partial
// match still open at the final byte of a string is replayed the same way before its
// end record. The controller steps the datapath, stalling while the output side is full,
// into a single result hold and one output register. A new item may be taken
// while the last result of the previous one still waits in the output register.
// keep_ands sits at byte address 0 of the register port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module search_text_normalizer_top
    import stn_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] in_byte
    input  logic              i_s_axis_tlast,   // is_last
    // Output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]        o_m_axis_tuser,   // [0] has_byte, [1] end_of_string, [2] altered
    output logic              o_m_axis_tlast,   // end_of_run
    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic    r_keep_ands;
    t_op     op;
    t_status status;

    // Register write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_ands <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_AW-1:2] == REG_KEEP_ANDS)) begin
            r_keep_ands <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_KEEP_ANDS) ?
                    {{(APB_DW-1){1'b0}}, r_keep_ands} : '0;

    stn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_op       (op),
        .i_status   (status)
    );

    stn_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_status    (status),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_keep_ands (r_keep_ands),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_has   (o_m_axis_tuser[0]),
        .o_out_eor   (o_m_axis_tlast),
        .o_out_eos   (o_m_axis_tuser[1]),
        .o_out_alt   (o_m_axis_tuser[2])
    );

endmodule

FILE: design/stn_checker.sv
// Port-level checks of the search text normalizer, bound to its top level.
module stn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [2:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // The end record is bare and closes its item
    a_eos_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
            (!o_m_axis_tuser[0] && o_m_axis_tlast && o_m_axis_tdata == 8'h00))
        else $error("end record malformed");

    // A result without a byte can only be the end record
    a_bare_is_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tuser[1])
        else $error("bare result outside end of string");

    // Altered flag travels only with the end record
    a_alt_on_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |-> !o_m_axis_tuser[2])
        else $error("altered flag on a data result");

    // Stalled output stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

endmodule

bind search_text_normalizer_top stn_checker u_stn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
